// ===== hdl/hemi_pkg.sv =====
// ----------------------------------------------------------------------------
// hemi_pkg
// Shared widths, constants and types for the hemisphere ambient shader.
// ----------------------------------------------------------------------------
package hemi_pkg;

  localparam int unsigned COORD_W = 32;  // Q16.16 coordinates
  localparam int unsigned DIFF_W  = 33;  // point - center
  localparam int unsigned NORM_W  = 24;  // normalized magnitudes
  localparam int unsigned UP_W    = 16;  // Q1.14 up components
  localparam int unsigned SQ_W    = 48;  // a*a
  localparam int unsigned PROD_W  = 41;  // signed a*up
  localparam int unsigned DOT_W   = 43;  // signed dot sum
  localparam int unsigned MAG_W   = 41;  // |dot|
  localparam int unsigned LEN2_W  = 50;  // sum of squares
  localparam int unsigned LEN_W   = 25;  // floor(sqrt(len2))
  localparam int unsigned NUM_W   = 57;  // |dot| << 16
  localparam int unsigned COS_W   = 31;  // |cos| in Q1.30
  localparam int unsigned RAD_W   = 62;  // 2^60 - cos^2
  localparam int unsigned SIN_W   = 31;  // sine in Q1.30
  localparam int unsigned H_W     = 16;  // h in units of 2^-16
  localparam int unsigned CH_W    = 16;  // one color channel, Q2.14
  localparam int unsigned COLOR_W = 48;  // packed r/g/b

  localparam logic [COS_W-1:0] COS_ONE = 31'h4000_0000;
  localparam logic [H_W-1:0]   H_HALF  = 16'h8000;

  typedef struct packed {
    logic pos_cos;  // dot > 0, near color is top
    logic degen;    // point equals center
  } tag_t;

  typedef enum logic [2:0] {
    REG_CENTER_X     = 3'd0,
    REG_CENTER_Y     = 3'd1,
    REG_CENTER_Z     = 3'd2,
    REG_UP_X         = 3'd3,
    REG_UP_Y         = 3'd4,
    REG_UP_Z         = 3'd5,
    REG_COLOR_TOP    = 3'd6,
    REG_COLOR_BOTTOM = 3'd7
  } reg_idx_e;

endpackage

// ===== hdl/hemi_isqrt.sv =====
// ----------------------------------------------------------------------------
// hemi_isqrt
// Pipelined integer square root, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
module hemi_isqrt
  import hemi_pkg::*;
#(
  parameter int unsigned RW = 25,  // root width, radicand is 2*RW bits
  parameter int unsigned SW = 2    // side data width
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [2*RW-1:0] radicand_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [RW-1:0]   root_o,
  output logic [SW-1:0]   side_o
);

  localparam int unsigned TW = 2*RW + 1;

  logic              vld_s  [RW+1];
  logic [2*RW-1:0]   rem_s  [RW+1];
  logic [RW-1:0]     root_s [RW+1];
  logic [SW-1:0]     side_s [RW+1];

  assign vld_s[0]  = valid_i;
  assign rem_s[0]  = radicand_i;
  assign root_s[0] = '0;
  assign side_s[0] = side_i;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int unsigned B = RW - 1 - k;
    logic            vld_q;
    logic [2*RW-1:0] rem_q;
    logic [RW-1:0]   root_q;
    logic [SW-1:0]   side_q;
    logic [TW-1:0]   trial;
    logic            fit;

    // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
    assign trial = (TW'(root_s[k]) << (B + 1)) | (TW'(1) << (2 * B));
    assign fit   = TW'(rem_s[k]) >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= vld_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q  <= fit ? rem_s[k] - trial[2*RW-1:0] : rem_s[k];
      root_q <= fit ? (root_s[k] | (RW'(1) << B)) : root_s[k];
      side_q <= side_s[k];
    end

    assign vld_s[k+1]  = vld_q;
    assign rem_s[k+1]  = rem_q;
    assign root_s[k+1] = root_q;
    assign side_s[k+1] = side_q;
  end

  assign valid_o = vld_s[RW];
  assign root_o  = root_s[RW];
  assign side_o  = side_s[RW];

endmodule

// ===== hdl/hemi_div.sv =====
// ----------------------------------------------------------------------------
// hemi_div
// Pipelined restoring divider, one quotient bit per stage, with an
// overflow flag for quotients of 2^QW and above.
// ----------------------------------------------------------------------------
module hemi_div
  import hemi_pkg::*;
#(
  parameter int unsigned NW = 57,  // numerator width
  parameter int unsigned DW = 25,  // divisor width
  parameter int unsigned QW = 31,  // quotient bits produced
  parameter int unsigned SW = 2    // side data width
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic          sat_o,
  output logic [SW-1:0] side_o
);

  localparam int unsigned TW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  // overflow check stage
  logic          pre_vld_q;
  logic [NW-1:0] pre_num_q;
  logic [DW-1:0] pre_den_q;
  logic [SW-1:0] pre_side_q;
  logic          pre_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q <= 1'b0;
    end else begin
      pre_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pre_num_q  <= num_i;
    pre_den_q  <= den_i;
    pre_side_q <= side_i;
    pre_sat_q  <= TW'(num_i) >= (TW'(den_i) << QW);
  end

  logic          vld_s  [QW+1];
  logic [NW-1:0] rem_s  [QW+1];
  logic [DW-1:0] den_s  [QW+1];
  logic [QW-1:0] quo_s  [QW+1];
  logic          sat_s  [QW+1];
  logic [SW-1:0] side_s [QW+1];

  assign vld_s[0]  = pre_vld_q;
  assign rem_s[0]  = pre_num_q;
  assign den_s[0]  = pre_den_q;
  assign quo_s[0]  = '0;
  assign sat_s[0]  = pre_sat_q;
  assign side_s[0] = pre_side_q;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int unsigned B = QW - 1 - k;
    logic          vld_q;
    logic [NW-1:0] rem_q;
    logic [DW-1:0] den_q;
    logic [QW-1:0] quo_q;
    logic          sat_q;
    logic [SW-1:0] side_q;
    logic [TW-1:0] sub;
    logic          fit;

    assign sub = TW'(den_s[k]) << B;
    assign fit = TW'(rem_s[k]) >= sub;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= vld_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q  <= fit ? rem_s[k] - sub[NW-1:0] : rem_s[k];
      quo_q  <= fit ? (quo_s[k] | (QW'(1) << B)) : quo_s[k];
      den_q  <= den_s[k];
      sat_q  <= sat_s[k];
      side_q <= side_s[k];
    end

    assign vld_s[k+1]  = vld_q;
    assign rem_s[k+1]  = rem_q;
    assign den_s[k+1]  = den_q;
    assign quo_s[k+1]  = quo_q;
    assign sat_s[k+1]  = sat_q;
    assign side_s[k+1] = side_q;
  end

  assign valid_o = vld_s[QW];
  assign quo_o   = quo_s[QW];
  assign sat_o   = sat_s[QW];
  assign side_o  = side_s[QW];

endmodule

// ===== hdl/hemi_blend.sv =====
// ----------------------------------------------------------------------------
// hemi_blend
// Two-stage color blend: near*(1-h) + far*h per channel, rounded and
// saturated; the second stage is the output register.
// ----------------------------------------------------------------------------
module hemi_blend
  import hemi_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [H_W-1:0]     h_i,
  input  tag_t               tag_i,
  input  logic [COLOR_W-1:0] top_i,
  input  logic [COLOR_W-1:0] bot_i,
  output logic               valid_o,
  output logic [CH_W-1:0]    red_o,
  output logic [CH_W-1:0]    green_o,
  output logic [CH_W-1:0]    blue_o,
  output logic               degen_o
);

  localparam int unsigned PW = CH_W + H_W + 1;

  logic [COLOR_W-1:0] near_c, far_c;
  logic [H_W:0]       w_near;

  assign near_c = tag_i.pos_cos ? top_i : bot_i;
  assign far_c  = tag_i.pos_cos ? bot_i : top_i;
  assign w_near = (H_W+1)'(17'h1_0000) - (H_W+1)'(h_i);

  // stage 1: products
  logic          m_vld_q;
  logic          m_degen_q;
  logic [PW-1:0] pn_q [3];
  logic [PW-1:0] pf_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else begin
      m_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    m_degen_q <= tag_i.degen;
    for (int c = 0; c < 3; c++) begin
      pn_q[c] <= PW'(near_c[CH_W*(2-c) +: CH_W]) * PW'(w_near);
      pf_q[c] <= PW'(far_c[CH_W*(2-c) +: CH_W]) * PW'(h_i);
    end
  end

  // stage 2: round, saturate, output register
  logic [PW:0]     sum_c [3];
  logic [CH_W-1:0] ch_d  [3];
  logic [CH_W-1:0] ch_q  [3];
  logic            o_vld_q;
  logic            o_degen_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_c[c] = ((PW+1)'(pn_q[c]) + (PW+1)'(pf_q[c]) + (PW+1)'(32768)) >> 16;
      ch_d[c]  = (sum_c[c] > (PW+1)'(65535)) ? '1 : sum_c[c][CH_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else begin
      o_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    o_degen_q <= m_degen_q;
    for (int c = 0; c < 3; c++) begin
      ch_q[c] <= ch_d[c];
    end
  end

  assign valid_o = o_vld_q;
  assign red_o   = ch_q[0];
  assign green_o = ch_q[1];
  assign blue_o  = ch_q[2];
  assign degen_o = o_degen_q;

endmodule

// ===== hdl/hemisphere_ambient_shade.sv =====
// ----------------------------------------------------------------------------
// hemisphere_ambient_shade
// Hemispherical ambient color for one 3D point per request, fully pipelined.
// ----------------------------------------------------------------------------
//
//  channel   signals                               direction  notes
//  --------  ------------------------------------  ---------  -----------------
//  request   start, busy, point_{x,y,z}_i          in         taken: start & !busy
//  result    done_o, red_o, green_o, blue_o,        out        one-cycle strobe
//            degenerate_o
//  config    psel, penable, pwrite, paddr,          in/out     APB, 64-bit data,
//            pwdata, prdata, pready                           reg i at 8*i
//
//  One request per cycle; busy is never raised. The pipeline depth comes
//  from the two bit-serial square roots (25 and 31 stages) and the 31-bit
//  divider. Reset clears all valid bits and loads the register defaults;
//  the receiver cannot stall, so the pipeline never holds.
//
//  Pipeline map:
//    1 diff, 2 abs, 3 max, 4 leading one, 5 normalize, 6 multiply,
//    7 sums, 8 |dot|, 9-33 sqrt(len2), 34-65 divide, 66 clamp,
//    67 cos^2, 68 1-cos^2, 69-99 sqrt, 100 h, 101-102 blend.
// ----------------------------------------------------------------------------
module hemisphere_ambient_shade
  import hemi_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // request
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] point_x_i,
  input  logic signed [COORD_W-1:0] point_y_i,
  input  logic signed [COORD_W-1:0] point_z_i,
  // result
  output logic                      done_o,
  output logic [CH_W-1:0]           red_o,
  output logic [CH_W-1:0]           green_o,
  output logic [CH_W-1:0]           blue_o,
  output logic                      degenerate_o,
  // config
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [5:0]                paddr,
  input  logic [63:0]               pwdata,
  output logic [63:0]               prdata,
  output logic                      pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [COORD_W-1:0] center_q [3];
  logic signed [UP_W-1:0]    up_q     [3];
  logic [COLOR_W-1:0]        color_top_q;
  logic [COLOR_W-1:0]        color_bot_q;
  logic                      cfg_we;
  reg_idx_e                  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q[0] <= '0;
      center_q[1] <= '0;
      center_q[2] <= '0;
      up_q[0]     <= '0;
      up_q[1]     <= 16'sd16384;
      up_q[2]     <= '0;
      color_top_q <= 48'h4000_4000_4000;
      color_bot_q <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_CENTER_X:     center_q[0] <= pwdata[COORD_W-1:0];
        REG_CENTER_Y:     center_q[1] <= pwdata[COORD_W-1:0];
        REG_CENTER_Z:     center_q[2] <= pwdata[COORD_W-1:0];
        REG_UP_X:         up_q[0]     <= pwdata[UP_W-1:0];
        REG_UP_Y:         up_q[1]     <= pwdata[UP_W-1:0];
        REG_UP_Z:         up_q[2]     <= pwdata[UP_W-1:0];
        REG_COLOR_TOP:    color_top_q <= pwdata[COLOR_W-1:0];
        REG_COLOR_BOTTOM: color_bot_q <= pwdata[COLOR_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_CENTER_X:     prdata = 64'(unsigned'(center_q[0]));
      REG_CENTER_Y:     prdata = 64'(unsigned'(center_q[1]));
      REG_CENTER_Z:     prdata = 64'(unsigned'(center_q[2]));
      REG_UP_X:         prdata = 64'(unsigned'(up_q[0]));
      REG_UP_Y:         prdata = 64'(unsigned'(up_q[1]));
      REG_UP_Z:         prdata = 64'(unsigned'(up_q[2]));
      REG_COLOR_TOP:    prdata = 64'(color_top_q);
      REG_COLOR_BOTTOM: prdata = 64'(color_bot_q);
      default:          prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Request side: never busy, one point per cycle
  // --------------------------------------------------------------------------
  logic req_acc;

  assign busy    = 1'b0;
  assign req_acc = start && !busy;

  // Valid bits for the front stages 1..8
  logic [8:1] fv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
    end else begin
      fv_q <= {fv_q[7:1], req_acc};
    end
  end

  // Stage 1: d = point - center, 33 bits signed
  logic signed [DIFF_W-1:0] diff_q [3];
  logic signed [COORD_W-1:0] pt [3];

  assign pt[0] = point_x_i;
  assign pt[1] = point_y_i;
  assign pt[2] = point_z_i;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      diff_q[i] <= DIFF_W'(pt[i]) - DIFF_W'(center_q[i]);
    end
  end

  // Stage 2: sign and magnitude, degenerate detect
  logic [DIFF_W-1:0] abs2_q [3];
  logic [2:0]        neg2_q;
  logic              degen2_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      neg2_q[i] <= diff_q[i][DIFF_W-1];
      abs2_q[i] <= diff_q[i][DIFF_W-1] ? DIFF_W'(-diff_q[i]) : DIFF_W'(diff_q[i]);
    end
    degen2_q <= (diff_q[0] == '0) && (diff_q[1] == '0) && (diff_q[2] == '0);
  end

  // Stage 3: largest magnitude
  logic [DIFF_W-1:0] abs3_q [3];
  logic [2:0]        neg3_q;
  logic              degen3_q;
  logic [DIFF_W-1:0] max3_q;
  logic [DIFF_W-1:0] max01;

  assign max01 = (abs2_q[0] > abs2_q[1]) ? abs2_q[0] : abs2_q[1];

  always_ff @(posedge clk_i) begin
    abs3_q   <= abs2_q;
    neg3_q   <= neg2_q;
    degen3_q <= degen2_q;
    max3_q   <= (max01 > abs2_q[2]) ? max01 : abs2_q[2];
  end

  // Stage 4: leading one of the max gives the normalizing shift, so that
  // the max lands in [2^23, 2^24)
  logic [DIFF_W-1:0] abs4_q [3];
  logic [2:0]        neg4_q;
  logic              degen4_q;
  logic              rsh4_q;
  logic [4:0]        amt4_q;
  logic [5:0]        lead;

  always_comb begin
    lead = '0;
    for (int j = 0; j < DIFF_W; j++) begin
      if (max3_q[j]) lead = 6'(j);
    end
  end

  always_ff @(posedge clk_i) begin
    abs4_q   <= abs3_q;
    neg4_q   <= neg3_q;
    degen4_q <= degen3_q;
    rsh4_q   <= lead >= 6'(NORM_W);
    amt4_q   <= (lead >= 6'(NORM_W)) ? 5'(lead - 6'(NORM_W - 1))
                                     : 5'(6'(NORM_W - 1) - lead);
  end

  // Stage 5: apply shift
  logic [NORM_W-1:0] norm5_q [3];
  logic [2:0]        neg5_q;
  logic              degen5_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      norm5_q[i] <= rsh4_q ? NORM_W'(abs4_q[i] >> amt4_q)
                           : NORM_W'(abs4_q[i] << amt4_q);
    end
    neg5_q   <= neg4_q;
    degen5_q <= degen4_q;
  end

  // Stage 6: squares and products with the up vector
  logic [SQ_W-1:0]          sq6_q [3];
  logic signed [PROD_W-1:0] pr6_q [3];
  logic [2:0]               neg6_q;
  logic                     degen6_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      sq6_q[i] <= SQ_W'(norm5_q[i]) * SQ_W'(norm5_q[i]);
      pr6_q[i] <= PROD_W'($signed({1'b0, norm5_q[i]})) * PROD_W'(up_q[i]);
    end
    neg6_q   <= neg5_q;
    degen6_q <= degen5_q;
  end

  // Stage 7: len2 and signed dot
  logic [LEN2_W-1:0]       len2_7_q;
  logic signed [DOT_W-1:0] dot7_q;
  logic                    degen7_q;
  logic signed [DOT_W-1:0] term [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      term[i] = neg6_q[i] ? -DOT_W'(pr6_q[i]) : DOT_W'(pr6_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    len2_7_q <= LEN2_W'(sq6_q[0]) + LEN2_W'(sq6_q[1]) + LEN2_W'(sq6_q[2]);
    dot7_q   <= term[0] + term[1] + term[2];
    degen7_q <= degen6_q;
  end

  // Stage 8: |dot| and branch select
  logic [LEN2_W-1:0] len2_8_q;
  logic [MAG_W-1:0]  mag8_q;
  tag_t              tag8_q;

  always_ff @(posedge clk_i) begin
    len2_8_q       <= len2_7_q;
    mag8_q         <= dot7_q[DOT_W-1] ? MAG_W'(-dot7_q) : MAG_W'(dot7_q);
    tag8_q.pos_cos <= (dot7_q > 0) && !degen7_q;
    tag8_q.degen   <= degen7_q;
  end

  // --------------------------------------------------------------------------
  // Length: L = floor(sqrt(len2)), 25 stages
  // --------------------------------------------------------------------------
  localparam int unsigned S1_W = MAG_W + $bits(tag_t);

  logic               l_vld;
  logic [LEN_W-1:0]   l_root;
  logic [S1_W-1:0]    l_side;
  logic [MAG_W-1:0]   l_mag;
  tag_t               l_tag;

  hemi_isqrt #(
    .RW (LEN_W),
    .SW (S1_W)
  ) u_len_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (fv_q[8]),
    .radicand_i (len2_8_q),
    .side_i     ({mag8_q, tag8_q}),
    .valid_o    (l_vld),
    .root_o     (l_root),
    .side_o     (l_side)
  );

  assign l_mag = l_side[S1_W-1 -: MAG_W];
  assign l_tag = tag_t'(l_side[$bits(tag_t)-1:0]);

  // --------------------------------------------------------------------------
  // |cos| = (|dot| << 16) / L, 1 + 31 stages
  // --------------------------------------------------------------------------
  logic             q_vld;
  logic [COS_W-1:0] q_quo;
  logic             q_sat;
  logic [$bits(tag_t)-1:0] q_side;
  tag_t             q_tag;

  hemi_div #(
    .NW (NUM_W),
    .DW (LEN_W),
    .QW (COS_W),
    .SW ($bits(tag_t))
  ) u_cos_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (l_vld),
    .num_i   ({l_mag, 16'h0000}),
    .den_i   (l_root),
    .side_i  (l_tag),
    .valid_o (q_vld),
    .quo_o   (q_quo),
    .sat_o   (q_sat),
    .side_o  (q_side)
  );

  assign q_tag = tag_t'(q_side);

  // Clamp to 1.0, square, then 1 - cos^2 (each a stage)
  logic [2:0]       bv_q;
  logic [COS_W-1:0] c30_q;
  logic [RAD_W-1:0] csq_q;
  logic [RAD_W-1:0] rad_q;
  tag_t             tag_b_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q <= '0;
    end else begin
      bv_q <= {bv_q[1:0], q_vld};
    end
  end

  always_ff @(posedge clk_i) begin
    c30_q      <= (q_sat || (q_quo > COS_ONE)) ? COS_ONE : q_quo;
    csq_q      <= RAD_W'(c30_q) * RAD_W'(c30_q);
    rad_q      <= (RAD_W'(1) << 60) - csq_q;
    tag_b_q[0] <= q_tag;
    tag_b_q[1] <= tag_b_q[0];
    tag_b_q[2] <= tag_b_q[1];
  end

  // --------------------------------------------------------------------------
  // Sine: floor(sqrt(2^60 - c^2)), 31 stages
  // --------------------------------------------------------------------------
  logic                    s_vld;
  logic [SIN_W-1:0]        s_root;
  logic [$bits(tag_t)-1:0] s_side;
  tag_t                    s_tag;

  hemi_isqrt #(
    .RW (SIN_W),
    .SW ($bits(tag_t))
  ) u_sin_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (bv_q[2]),
    .radicand_i (rad_q),
    .side_i     (tag_b_q[2]),
    .valid_o    (s_vld),
    .root_o     (s_root),
    .side_o     (s_side)
  );

  assign s_tag = tag_t'(s_side);

  // h = (sin + 2^14) >> 15; a degenerate point takes cos 0, so h is one half
  logic           h_vld_q;
  logic [H_W-1:0] h_q;
  tag_t           h_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_vld_q <= 1'b0;
    end else begin
      h_vld_q <= s_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q     <= s_tag.degen ? H_HALF
                           : H_W'((32'(s_root) + 32'd16384) >> 15);
    h_tag_q <= s_tag;
  end

  // --------------------------------------------------------------------------
  // Blend and output register
  // --------------------------------------------------------------------------
  hemi_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (h_vld_q),
    .h_i     (h_q),
    .tag_i   (h_tag_q),
    .top_i   (color_top_q),
    .bot_i   (color_bot_q),
    .valid_o (done_o),
    .red_o   (red_o),
    .green_o (green_o),
    .blue_o  (blue_o),
    .degen_o (degenerate_o)
  );

`ifndef SYNTHESIS
  localparam int unsigned LATENCY = 102;

  // every accepted request comes out after the fixed pipeline depth
  a_req_to_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |-> ##LATENCY done_o)
    else $error("request did not complete after pipeline depth");

  // no result without a request at the matching time
  a_done_has_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(req_acc, LATENCY))
    else $error("result without matching request");

  // divider output valid lines up with the front of the pipeline
  a_div_align : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_vld |-> $past(fv_q[8], LEN_W + COS_W + 1))
    else $error("divider output out of step with front end");
`endif

endmodule
